[rtl/core/yuv_ups_pkg.sv]
// ============================================================================
// yuv_ups_pkg
// Shared types and constants of the YUYV to YUV 4:4:4 chroma upsampler.
// ============================================================================
package yuv_ups_pkg;

    localparam int MAX_PAIRS    = 2048;
    localparam int PAIR_POS_W   = $clog2(MAX_PAIRS);
    localparam int CFG_W        = 12;
    localparam int CFG_RESET    = 320;
    localparam int SAMPLE_W     = 8;
    localparam int IN_DATA_W    = 4 * SAMPLE_W;
    localparam int OUT_DATA_W   = 3 * SAMPLE_W;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t chroma_red;
        sample_t luma_odd;
        sample_t chroma_blue;
        sample_t luma_even;
    } pair_t;

    typedef struct packed {
        logic  emit_held;
        logic  ends;
        pair_t held;
        pair_t cur;
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_HELD_EVEN = 2'd0,
        KIND_HELD_ODD  = 2'd1,
        KIND_CUR_EVEN  = 2'd2,
        KIND_CUR_ODD   = 2'd3
    } pix_kind_t;

endpackage

[rtl/core/yuv_ups_front.sv]
// ============================================================================
// yuv_ups_front
// Accepts YUYV pairs, tracks the line position and issues pixel commands.
// ============================================================================
module yuv_ups_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [yuv_ups_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [yuv_ups_pkg::CFG_W-1:0]         cfg_data,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output yuv_ups_pkg::cmd_t                     push_cmd
);

    logic [yuv_ups_pkg::CFG_W-1:0]      pairs_per_line_reg;
    logic [yuv_ups_pkg::PAIR_POS_W-1:0] pos_reg;
    logic [yuv_ups_pkg::PAIR_POS_W-1:0] pos_next;
    yuv_ups_pkg::pair_t                 held_reg;
    yuv_ups_pkg::pair_t                 cur;
    logic [yuv_ups_pkg::PAIR_POS_W-1:0] last_pos;
    logic [yuv_ups_pkg::CFG_W-1:0]      cfg_minus_one;
    logic                               ends;
    logic                               accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && push_ready;
    assign cur           = yuv_ups_pkg::pair_t'(s_axis_tdata);
    assign cfg_minus_one = pairs_per_line_reg - yuv_ups_pkg::CFG_W'(1);

    always_comb
    begin
        if (pairs_per_line_reg == '0)
        begin
            last_pos = '0;
        end
        else if (pairs_per_line_reg > yuv_ups_pkg::CFG_W'(yuv_ups_pkg::MAX_PAIRS))
        begin
            last_pos = yuv_ups_pkg::PAIR_POS_W'(yuv_ups_pkg::MAX_PAIRS - 1);
        end
        else
        begin
            last_pos = cfg_minus_one[yuv_ups_pkg::PAIR_POS_W-1:0];
        end
    end

    assign ends     = (pos_reg >= last_pos);
    assign pos_next = ends ? '0 : pos_reg + yuv_ups_pkg::PAIR_POS_W'(1);

    assign push_valid         = accept && ((pos_reg != '0) || ends);
    assign push_cmd.emit_held = (pos_reg != '0);
    assign push_cmd.ends      = ends;
    assign push_cmd.held      = held_reg;
    assign push_cmd.cur       = cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_per_line_reg <= yuv_ups_pkg::CFG_W'(yuv_ups_pkg::CFG_RESET);
            pos_reg            <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                pairs_per_line_reg <= cfg_data;
            end
            if (accept)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= cur;
        end
    end

endmodule

[rtl/core/yuv_ups_fifo.sv]
// ============================================================================
// yuv_ups_fifo
// Short command queue between the front and back parts.
// ============================================================================
module yuv_ups_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  yuv_ups_pkg::cmd_t  push_cmd,
    output logic               pop_valid,
    input  logic               pop_ready,
    output yuv_ups_pkg::cmd_t  pop_cmd
);

    yuv_ups_pkg::cmd_t                  entries_reg [yuv_ups_pkg::FIFO_DEPTH];
    logic [yuv_ups_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [yuv_ups_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [yuv_ups_pkg::FIFO_CNT_W-1:0] count_reg;
    logic                               do_push;
    logic                               do_pop;

    assign push_ready = (count_reg != yuv_ups_pkg::FIFO_CNT_W'(yuv_ups_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [yuv_ups_pkg::FIFO_PTR_W-1:0] ptr_inc
    (
        input logic [yuv_ups_pkg::FIFO_PTR_W-1:0] ptr
    );
        if (ptr == yuv_ups_pkg::FIFO_PTR_W'(yuv_ups_pkg::FIFO_DEPTH - 1))
        begin
            return '0;
        end
        return ptr + yuv_ups_pkg::FIFO_PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + yuv_ups_pkg::FIFO_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - yuv_ups_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/yuv_ups_back.sv]
// ============================================================================
// yuv_ups_back
// Expands each command into its 4:4:4 pixels, one per cycle while the
// output is not stalled, into a registered output stage.
// ============================================================================
module yuv_ups_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  yuv_ups_pkg::cmd_t                     cmd,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [yuv_ups_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                                  m_axis_tlast,
    output logic                                  m_axis_tuser
);

    logic [1:0]                              idx_reg;
    logic [1:0]                              idx_next;
    logic                                    out_valid_reg;
    logic [yuv_ups_pkg::OUT_DATA_W-1:0]      out_data_reg;
    logic                                    out_last_reg;
    logic                                    out_user_reg;
    logic                                    out_free;
    logic                                    emit;
    logic                                    is_last;
    yuv_ups_pkg::pix_kind_t                  kind;
    yuv_ups_pkg::pix_kind_t                  last_kind;
    yuv_ups_pkg::sample_t                    pix_luma;
    yuv_ups_pkg::sample_t                    pix_cb;
    yuv_ups_pkg::sample_t                    pix_cr;
    logic [yuv_ups_pkg::SAMPLE_W:0]          sum_cb;
    logic [yuv_ups_pkg::SAMPLE_W:0]          sum_cr;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign emit      = cmd_valid && out_free;
    assign kind      = yuv_ups_pkg::pix_kind_t'((cmd.emit_held ? 2'd0 : 2'd2) + idx_reg);
    assign last_kind = cmd.ends ? yuv_ups_pkg::KIND_CUR_ODD : yuv_ups_pkg::KIND_HELD_ODD;
    assign is_last   = (kind == last_kind);
    assign cmd_ready = out_free && is_last;
    assign idx_next  = is_last ? 2'd0 : idx_reg + 2'd1;

    assign sum_cb = {1'b0, cmd.held.chroma_blue} + {1'b0, cmd.cur.chroma_blue};
    assign sum_cr = {1'b0, cmd.held.chroma_red} + {1'b0, cmd.cur.chroma_red};

    always_comb
    begin
        unique case (kind)
            yuv_ups_pkg::KIND_HELD_EVEN:
            begin
                pix_luma = cmd.held.luma_even;
                pix_cb   = cmd.held.chroma_blue;
                pix_cr   = cmd.held.chroma_red;
            end
            yuv_ups_pkg::KIND_HELD_ODD:
            begin
                pix_luma = cmd.held.luma_odd;
                pix_cb   = sum_cb[yuv_ups_pkg::SAMPLE_W:1];
                pix_cr   = sum_cr[yuv_ups_pkg::SAMPLE_W:1];
            end
            yuv_ups_pkg::KIND_CUR_EVEN:
            begin
                pix_luma = cmd.cur.luma_even;
                pix_cb   = cmd.cur.chroma_blue;
                pix_cr   = cmd.cur.chroma_red;
            end
            default:
            begin
                pix_luma = cmd.cur.luma_odd;
                pix_cb   = cmd.cur.chroma_blue;
                pix_cr   = cmd.cur.chroma_red;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                idx_reg <= idx_next;
            end
            if (out_free)
            begin
                out_valid_reg <= cmd_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {pix_cr, pix_cb, pix_luma};
            out_last_reg <= (kind == yuv_ups_pkg::KIND_CUR_ODD);
            out_user_reg <= is_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

[rtl/core/yuyv_to_yuv444_upsampler.sv]
// ============================================================================
// yuyv_to_yuv444_upsampler
// Converts YUYV 4:2:2 pairs into YUV 4:4:4 pixels with linear chroma
// interpolation. Each pair is held until the next pair of its line arrives;
// the first pair of a longer line yields nothing, later pairs yield two
// pixels and the last pair yields four; a one-pair line yields two. Pixels
// leave a registered output stage at one per cycle unless the output stalls,
// two per pair on average; a two-entry command queue lets the input keep
// accepting while the output expands earlier pairs. The line length register
// is taken at once and does not move the position within the current line.
// ============================================================================
module yuyv_to_yuv444_upsampler
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // luma_even, chroma_blue, luma_odd, chroma_red
    input  logic [yuv_ups_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // pix_luma, pix_cb, pix_cr
    output logic [yuv_ups_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                                  m_axis_tlast,
    // run_last
    output logic                                  m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [yuv_ups_pkg::CFG_W-1:0]         cfg_data
);

    logic              push_valid;
    logic              push_ready;
    yuv_ups_pkg::cmd_t push_cmd;
    logic              pop_valid;
    logic              pop_ready;
    yuv_ups_pkg::cmd_t pop_cmd;

    yuv_ups_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    yuv_ups_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    yuv_ups_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (pop_valid),
        .cmd_ready     (pop_ready),
        .cmd           (pop_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the YUYV to YUV 4:4:4 upsampler. YUYV pairs are
// streamed in under several idle and stall patterns, each accepted pair is
// run through a local model of the chroma interpolation, and every output
// pixel is compared field by field with the oldest predicted pixel. The line
// length register is swept over its extremes, including mid-line writes.
// ============================================================================
module tb_top;

    import yuv_ups_pkg::*;

    typedef struct {
        sample_t luma;
        sample_t cb;
        sample_t cr;
        logic    line_end;
        logic    run_last;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;

    pixel_t                pending_pixels[$];
    int                    error_count    = 0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    hold_left      = 0;

    pair_t                 held_pair;
    int unsigned           pair_pos;
    logic [CFG_W-1:0]      line_pairs;

    yuyv_to_yuv444_upsampler DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic sample_t chroma_mean(input sample_t a, input sample_t b);
        logic [SAMPLE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[SAMPLE_W:1];
    endfunction

    function automatic void push_pixels(input pair_t p, input sample_t next_cb,
                                        input sample_t next_cr, input logic eol,
                                        input logic last);
        pixel_t px;
        px.luma     = p.luma_even;
        px.cb       = p.chroma_blue;
        px.cr       = p.chroma_red;
        px.line_end = 1'b0;
        px.run_last = 1'b0;
        pending_pixels.push_back(px);
        px.luma     = p.luma_odd;
        px.cb       = chroma_mean(p.chroma_blue, next_cb);
        px.cr       = chroma_mean(p.chroma_red, next_cr);
        px.line_end = eol;
        px.run_last = last;
        pending_pixels.push_back(px);
    endfunction

    function automatic void upsample_pair(input pair_t cur);
        int unsigned len;
        logic        ends;
        len = (line_pairs == 0) ? 1 : ((line_pairs > MAX_PAIRS) ? MAX_PAIRS : line_pairs);
        ends = (pair_pos >= len - 1);
        if (pair_pos > 0)
            push_pixels(held_pair, cur.chroma_blue, cur.chroma_red, 1'b0, !ends);
        if (ends)
        begin
            push_pixels(cur, cur.chroma_blue, cur.chroma_red, 1'b1, 1'b1);
            pair_pos = 0;
        end
        else
        begin
            pair_pos = pair_pos + 1;
        end
        held_pair = cur;
    endfunction

    function automatic pair_t mk_pair(input sample_t ye, input sample_t cb,
                                      input sample_t yo, input sample_t cr);
        pair_t p;
        p.luma_even   = ye;
        p.chroma_blue = cb;
        p.luma_odd    = yo;
        p.chroma_red  = cr;
        return p;
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return sample_t'($urandom_range(255));
        endcase
    endfunction

    function automatic int idle_gap();
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        return gap;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            error_count++;
        end
    endfunction

    // Output side: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_t exp_px;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel transfer with no prediction waiting: tdata %0h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                check_field("pix_luma", exp_px.luma, m_axis_tdata[7:0]);
                check_field("pix_cb", exp_px.cb, m_axis_tdata[15:8]);
                check_field("pix_cr", exp_px.cr, m_axis_tdata[23:16]);
                check_field("line_end", exp_px.line_end, m_axis_tlast);
                check_field("run_last", exp_px.run_last, m_axis_tuser);
            end
        end
    end

    task automatic send_pairs(input pair_t items[$]);
        int i;
        int gap;
        gap = idle_gap();
        if (gap > 0)
            repeat (gap) @(posedge clk);
        s_axis_tdata  <= items[0];
        s_axis_tvalid <= 1'b1;
        for (i = 0; i < items.size(); i++)
        begin
            do
                @(posedge clk);
            while (!s_axis_tready);
            upsample_pair(items[i]);
            gap = (i + 1 < items.size()) ? idle_gap() : 0;
            if (i + 1 < items.size() && gap == 0)
            begin
                s_axis_tdata <= items[i + 1];
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                if (i + 1 < items.size())
                begin
                    repeat (gap) @(posedge clk);
                    s_axis_tdata  <= items[i + 1];
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_line_pairs(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        line_pairs = value;
    endtask

    task automatic test_reset_length();
        pair_t items[$];
        items = '{mk_pair(8'h00, 8'h00, 8'hFF, 8'hFF),
                  mk_pair(8'hFF, 8'hFF, 8'h00, 8'h00),
                  mk_pair(8'h55, 8'hAA, 8'hAA, 8'h55)};
        send_pairs(items);
    endtask

    // Shortening the line mid-way makes the next pair close it.
    task automatic test_midline_shorten();
        pair_t items[$];
        write_line_pairs(12'd1);
        items = '{mk_pair(8'h12, 8'h34, 8'h56, 8'h78)};
        send_pairs(items);
    endtask

    task automatic test_single_pair_lines();
        pair_t items[$];
        items = '{mk_pair(8'h00, 8'h00, 8'h00, 8'h00),
                  mk_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF),
                  mk_pair(8'hAA, 8'h55, 8'h55, 8'hAA)};
        send_pairs(items);
        write_line_pairs(12'd0);
        items = '{mk_pair(8'h01, 8'h80, 8'hFE, 8'h7F),
                  mk_pair(8'h80, 8'h01, 8'h7F, 8'hFE)};
        send_pairs(items);
    endtask

    task automatic test_chroma_mean();
        pair_t items[$];
        write_line_pairs(12'd3);
        items = '{mk_pair(8'h10, 8'hFF, 8'h20, 8'hFE),
                  mk_pair(8'h30, 8'hFE, 8'h40, 8'hFF),
                  mk_pair(8'h50, 8'h00, 8'h60, 8'h01),
                  mk_pair(8'hFF, 8'h01, 8'h00, 8'h00),
                  mk_pair(8'h00, 8'h00, 8'hFF, 8'hFF),
                  mk_pair(8'h7F, 8'hFF, 8'h80, 8'h00)};
        send_pairs(items);
    endtask

    task automatic test_long_lines();
        pair_t items[$];
        write_line_pairs(12'hFFF);
        items = '{mk_pair(8'h11, 8'h22, 8'h33, 8'h44),
                  mk_pair(8'h55, 8'h66, 8'h77, 8'h88),
                  mk_pair(8'h99, 8'hAA, 8'hBB, 8'hCC),
                  mk_pair(8'hDD, 8'hEE, 8'hFF, 8'h00)};
        send_pairs(items);
        write_line_pairs(12'd2048);
        items = '{mk_pair(8'h01, 8'h02, 8'h03, 8'h04),
                  mk_pair(8'h05, 8'h06, 8'h07, 8'h08)};
        send_pairs(items);
        write_line_pairs(12'd2);
        items = '{mk_pair(8'hF0, 8'h0F, 8'hE1, 8'h1E)};
        send_pairs(items);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count);
        pair_t items[$];
        int i;
        write_line_pairs(CFG_W'($urandom_range(1, 8)));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (i = 0; i < count; i++)
            items.push_back(mk_pair(rand_sample(), rand_sample(), rand_sample(),
                                    rand_sample()));
        send_pairs(items);
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // The output is held off long enough for the input side to back up.
    task automatic test_output_backpressure();
        pair_t items[$];
        int i;
        write_line_pairs(12'd5);
        for (i = 0; i < 24; i++)
            items.push_back(mk_pair(rand_sample(), rand_sample(), rand_sample(),
                                    rand_sample()));
        hold_left = 300;
        send_pairs(items);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        held_pair     = '0;
        pair_pos      = 0;
        line_pairs    = CFG_W'(CFG_RESET);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_length();
        test_midline_shorten();
        test_single_pair_lines();
        test_chroma_mean();
        test_long_lines();
        test_random_traffic(0, 0, 21);
        test_random_traffic(75, 0, 21);
        test_random_traffic(0, 75, 21);
        test_random_traffic(19, 19, 21);
        test_output_backpressure();

        wait_idle();
        if (error_count == 0 && pending_pixels.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
